FILE: design/occupancy_grid_box_collision_top_defines.svh
// Assertion macros shared by the occupancy grid collision block.
// Taken in by the top level; depends on nothing else.
`ifndef OCCUPANCY_GRID_BOX_COLLISION_TOP_DEFINES_SVH
`define OCCUPANCY_GRID_BOX_COLLISION_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define OGBC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("occupancy grid check failed");

// Next-cycle implication, disabled while reset is high
`define OGBC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("occupancy grid check failed");

`endif

FILE: design/ogbc_pkg.sv
// Shared constants, types and codes for the occupancy grid collision block.
// Used by the span, sequencer and top modules; depends on nothing.
`timescale 1ns / 1ps

package ogbc_pkg;

   // Grid and store sizing
   localparam int MAX_DIM     = 64;
   localparam int MAX_CELLS   = 4096;
   localparam int DIM_W       = $clog2(MAX_DIM);
   localparam int DIM_CW      = $clog2(MAX_DIM + 1);
   localparam int MEM_DEPTH   = MAX_CELLS / MAX_DIM;
   localparam int MEM_AW      = $clog2(MEM_DEPTH);

   // Field and register widths
   localparam int GRID_REG_W  = 7;
   localparam int CELL_SIZE_W = 16;
   localparam int COORD_W     = 32;
   localparam int BOX_W       = 20;
   localparam int IDX_W       = 12;
   localparam int VAL_W       = 8;

   // Row base y*grid_width, raw width register up to its full code range
   localparam int BASE_W      = $clog2(MAX_DIM * (2 ** GRID_REG_W));
   localparam int WADDR_W     = BASE_W - DIM_W;

   // Doubled coordinates plus margin for offsets and bounds
   localparam int CW          = COORD_W + 4;

   // Configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   localparam csr_addr_type CSR_GRID_WIDTH  = 3'd0;
   localparam csr_addr_type CSR_GRID_HEIGHT = 3'd1;
   localparam csr_addr_type CSR_CELL_SIZE   = 3'd2;
   localparam csr_addr_type CSR_ORIGIN_X    = 3'd3;
   localparam csr_addr_type CSR_ORIGIN_Y    = 3'd4;

   // Register reset values
   localparam logic [GRID_REG_W-1:0]  GRID_WIDTH_RST  = 7'd64;
   localparam logic [GRID_REG_W-1:0]  GRID_HEIGHT_RST = 7'd64;
   localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RST   = 16'd1024;

   // Request payload layout, lowest bit first
   localparam int CELL_INDEX_LSB = 0;
   localparam int CELL_VALUE_LSB = CELL_INDEX_LSB + IDX_W;
   localparam int POS_X_LSB      = CELL_VALUE_LSB + VAL_W;
   localparam int POS_Y_LSB      = POS_X_LSB + COORD_W;
   localparam int BOX_SIZE_LSB   = POS_Y_LSB + COORD_W;
   localparam int REQ_FIELDS_W   = BOX_SIZE_LSB + BOX_W;
   localparam int REQ_TDATA_W    = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W    = 8;

   // Item kinds carried in req_tuser
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Cell value meaning unknown, counted as occupied
   localparam logic signed [VAL_W-1:0] OCC_UNKNOWN = -8'sd1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_WR,
      ST_XSCAN,
      ST_YTEST,
      ST_YCHK,
      ST_DONE
   } ctrl_state_type;

   // Control of one axis sweep unit
   typedef struct packed {
      logic init;
      logic step;
   } span_ctl_type;

   // Finished query handed to the output register
   typedef struct packed {
      logic valid;
      logic collision;
   } result_type;

endpackage

FILE: design/ogbc_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// Holds the occupancy bitmap; depends on nothing.
`timescale 1ns / 1ps

module ogbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read ports
   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: design/ogbc_span.sv
// One axis sweep unit: walks cell centers along an axis and flags
// those that lie inside the query box. Depends on ogbc_pkg.
`timescale 1ns / 1ps

module ogbc_span (
   input  logic                                   clock,
   input  ogbc_pkg::span_ctl_type                 ctl,
   input  logic signed [ogbc_pkg::COORD_W-1:0]    pos,
   input  logic signed [ogbc_pkg::COORD_W-1:0]    origin,
   input  logic        [ogbc_pkg::CELL_SIZE_W-1:0] cell_size,
   input  logic        [ogbc_pkg::BOX_W-1:0]      box_size,
   output logic                                   hit
);

   logic signed [ogbc_pkg::CW-1:0] lo_ff, lo_in;
   logic signed [ogbc_pkg::CW-1:0] hi_ff, hi_in;
   logic signed [ogbc_pkg::CW-1:0] ctr_ff, ctr_in;
   logic signed [ogbc_pkg::CW-1:0] pos2;
   logic signed [ogbc_pkg::CW-1:0] org2;
   logic signed [ogbc_pkg::CW-1:0] reach;
   logic signed [ogbc_pkg::CW-1:0] cs_ext;
   logic signed [ogbc_pkg::CW-1:0] step2;

   // Doubled units keep the half-cell center exact
   assign pos2   = ogbc_pkg::CW'(pos) <<< 1;
   assign org2   = ogbc_pkg::CW'(origin) <<< 1;
   assign cs_ext = $signed(ogbc_pkg::CW'(cell_size));
   assign step2  = cs_ext <<< 1;
   assign reach  = $signed(ogbc_pkg::CW'(box_size)) + cs_ext;

   // |2*pos - center2| < reach  <=>  2*pos - reach < center2 < 2*pos + reach
   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      ctr_in = ctr_ff;
      if (ctl.init) begin
         lo_in  = pos2 - reach;
         hi_in  = pos2 + reach;
         ctr_in = org2 + cs_ext;
      end else if (ctl.step) begin
         ctr_in = ctr_ff + step2;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      ctr_ff <= ctr_in;
   end

   assign hit = (ctr_ff > lo_ff) && (ctr_ff < hi_ff);

endmodule

FILE: design/ogbc_ctrl.sv
// Sequencer for loads and queries: read-modify-write of bitmap words,
// column mask sweep and row scan. Depends on ogbc_pkg.
`timescale 1ns / 1ps

module ogbc_ctrl (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_accept,
   input  logic                                    req_action,
   input  logic        [ogbc_pkg::IDX_W-1:0]       cell_index,
   input  logic signed [ogbc_pkg::VAL_W-1:0]       cell_value,
   input  logic        [ogbc_pkg::GRID_REG_W-1:0]  grid_width,
   input  logic        [ogbc_pkg::GRID_REG_W-1:0]  grid_height,
   input  logic                                    out_free,
   output logic                                    req_ready,
   output ogbc_pkg::span_ctl_type                  xspan_ctl,
   output ogbc_pkg::span_ctl_type                  yspan_ctl,
   input  logic                                    x_hit,
   input  logic                                    y_hit,
   output logic                                    wr_en,
   output logic        [ogbc_pkg::MEM_AW-1:0]      wr_addr,
   output logic        [ogbc_pkg::MAX_DIM-1:0]     wr_data,
   output logic        [ogbc_pkg::MEM_AW-1:0]      rd_addr_a,
   output logic        [ogbc_pkg::MEM_AW-1:0]      rd_addr_b,
   input  logic        [ogbc_pkg::MAX_DIM-1:0]     rd_data_a,
   input  logic        [ogbc_pkg::MAX_DIM-1:0]     rd_data_b,
   output ogbc_pkg::result_type                    result
);

   ogbc_pkg::ctrl_state_type state_ff, state_in;

   logic [ogbc_pkg::IDX_W-1:0]     ld_idx_ff, ld_idx_in;
   logic                           ld_occ_ff, ld_occ_in;
   logic [ogbc_pkg::DIM_CW-1:0]    cnt_ff, cnt_in;
   logic [ogbc_pkg::BASE_W-1:0]    base_ff, base_in;
   logic [ogbc_pkg::MAX_DIM-1:0]   mask_ff, mask_in;
   logic [ogbc_pkg::DIM_W-1:0]     off_ff, off_in;
   logic                           ok_a_ff, ok_a_in;
   logic                           ok_b_ff, ok_b_in;
   logic                           hit_ff, hit_in;
   logic [ogbc_pkg::MEM_DEPTH-1:0] valid_ff, valid_in;

   logic [ogbc_pkg::DIM_CW-1:0]    dim_w;
   logic [ogbc_pkg::DIM_CW-1:0]    dim_h;
   logic [ogbc_pkg::MEM_AW-1:0]    ld_word;
   logic [ogbc_pkg::WADDR_W-1:0]   wa_a;
   logic [ogbc_pkg::WADDR_W-1:0]   wa_b;
   logic [ogbc_pkg::MEM_AW-1:0]    scan_addr_a;
   logic [ogbc_pkg::MEM_AW-1:0]    scan_addr_b;
   logic                           wa_a_in_range;
   logic                           wa_b_in_range;
   logic [2*ogbc_pkg::MAX_DIM-1:0] pair;
   logic [2*ogbc_pkg::MAX_DIM-1:0] pair_shift;
   logic                           row_hit;
   logic                           x_last;
   logic                           y_end;
   logic [ogbc_pkg::MAX_DIM-1:0]   old_word;

   // Grid size clamped to the largest supported dimension
   assign dim_w = (int'(grid_width) > ogbc_pkg::MAX_DIM) ?
                  ogbc_pkg::DIM_CW'(ogbc_pkg::MAX_DIM) : ogbc_pkg::DIM_CW'(grid_width);
   assign dim_h = (int'(grid_height) > ogbc_pkg::MAX_DIM) ?
                  ogbc_pkg::DIM_CW'(ogbc_pkg::MAX_DIM) : ogbc_pkg::DIM_CW'(grid_height);

   assign x_last = (cnt_ff == dim_w - ogbc_pkg::DIM_CW'(1));
   assign y_end  = (cnt_ff == dim_h);

   // Word addresses of the row that starts at base_ff; it may straddle two words
   assign ld_word       = ogbc_pkg::MEM_AW'(ld_idx_ff >> ogbc_pkg::DIM_W);
   assign wa_a          = base_ff[ogbc_pkg::BASE_W-1:ogbc_pkg::DIM_W];
   assign wa_b          = wa_a + ogbc_pkg::WADDR_W'(1);
   assign wa_a_in_range = (int'(wa_a) < ogbc_pkg::MEM_DEPTH);
   assign wa_b_in_range = (int'(wa_b) < ogbc_pkg::MEM_DEPTH);
   assign scan_addr_a   = wa_a[ogbc_pkg::MEM_AW-1:0];
   assign scan_addr_b   = wa_b[ogbc_pkg::MEM_AW-1:0];

   // Row window: words never written or past the store read as empty
   assign pair       = {(ok_b_ff ? rd_data_b : '0), (ok_a_ff ? rd_data_a : '0)};
   assign pair_shift = pair >> off_ff;
   assign row_hit    = |(pair_shift[ogbc_pkg::MAX_DIM-1:0] & mask_ff);

   // Word under modification for a load
   assign old_word = valid_ff[ld_word] ? rd_data_a : '0;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ogbc_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_action == ogbc_pkg::ACT_LOAD) begin
                  state_in = ogbc_pkg::ST_LD_RD;
               end else if ((dim_w == '0) || (dim_h == '0)) begin
                  state_in = ogbc_pkg::ST_DONE;
               end else begin
                  state_in = ogbc_pkg::ST_XSCAN;
               end
            end
         end
         ogbc_pkg::ST_LD_RD: state_in = ogbc_pkg::ST_LD_WR;
         ogbc_pkg::ST_LD_WR: state_in = ogbc_pkg::ST_IDLE;
         ogbc_pkg::ST_XSCAN: begin
            if (x_last) begin
               state_in = ogbc_pkg::ST_YTEST;
            end
         end
         ogbc_pkg::ST_YTEST: begin
            if (y_end) begin
               state_in = ogbc_pkg::ST_DONE;
            end else if (y_hit) begin
               state_in = ogbc_pkg::ST_YCHK;
            end
         end
         ogbc_pkg::ST_YCHK: begin
            state_in = row_hit ? ogbc_pkg::ST_DONE : ogbc_pkg::ST_YTEST;
         end
         ogbc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ogbc_pkg::ST_IDLE;
            end
         end
         default: state_in = ogbc_pkg::ST_IDLE;
      endcase
   end

   // Outputs: handshake, sweep units, memory ports, result
   always_comb begin
      req_ready      = (state_ff == ogbc_pkg::ST_IDLE);
      xspan_ctl.init = req_accept && (req_action == ogbc_pkg::ACT_QUERY);
      yspan_ctl.init = req_accept && (req_action == ogbc_pkg::ACT_QUERY);
      xspan_ctl.step = (state_ff == ogbc_pkg::ST_XSCAN);
      yspan_ctl.step = ((state_ff == ogbc_pkg::ST_YTEST) && !y_end && !y_hit) ||
                       ((state_ff == ogbc_pkg::ST_YCHK) && !row_hit);
      wr_en          = (state_ff == ogbc_pkg::ST_LD_WR);
      wr_addr        = ld_word;
      wr_data        = old_word;
      wr_data[ld_idx_ff[ogbc_pkg::DIM_W-1:0]] = ld_occ_ff;
      rd_addr_a      = (state_ff == ogbc_pkg::ST_LD_RD) ? ld_word : scan_addr_a;
      rd_addr_b      = scan_addr_b;
      result.valid     = (state_ff == ogbc_pkg::ST_DONE) && out_free;
      result.collision = hit_ff;
   end

   // Datapath registers
   always_comb begin
      ld_idx_in = ld_idx_ff;
      ld_occ_in = ld_occ_ff;
      cnt_in    = cnt_ff;
      base_in   = base_ff;
      mask_in   = mask_ff;
      off_in    = off_ff;
      ok_a_in   = ok_a_ff;
      ok_b_in   = ok_b_ff;
      hit_in    = hit_ff;
      valid_in  = valid_ff;
      case (state_ff)
         ogbc_pkg::ST_IDLE: begin
            if (req_accept) begin
               ld_idx_in = cell_index;
               ld_occ_in = (cell_value > 0) || (cell_value == ogbc_pkg::OCC_UNKNOWN);
               cnt_in    = '0;
               base_in   = '0;
               mask_in   = '0;
               hit_in    = 1'b0;
            end
         end
         ogbc_pkg::ST_LD_WR: begin
            valid_in[ld_word] = 1'b1;
         end
         ogbc_pkg::ST_XSCAN: begin
            mask_in[cnt_ff[ogbc_pkg::DIM_W-1:0]] = x_hit;
            cnt_in = x_last ? '0 : cnt_ff + ogbc_pkg::DIM_CW'(1);
         end
         ogbc_pkg::ST_YTEST: begin
            if (!y_end) begin
               if (y_hit) begin
                  off_in  = base_ff[ogbc_pkg::DIM_W-1:0];
                  ok_a_in = wa_a_in_range && valid_ff[scan_addr_a];
                  ok_b_in = wa_b_in_range && valid_ff[scan_addr_b];
               end else begin
                  cnt_in  = cnt_ff + ogbc_pkg::DIM_CW'(1);
                  base_in = base_ff + ogbc_pkg::BASE_W'(grid_width);
               end
            end
         end
         ogbc_pkg::ST_YCHK: begin
            hit_in = row_hit;
            if (!row_hit) begin
               cnt_in  = cnt_ff + ogbc_pkg::DIM_CW'(1);
               base_in = base_ff + ogbc_pkg::BASE_W'(grid_width);
            end
         end
         default: ;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ogbc_pkg::ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ld_idx_ff <= ld_idx_in;
      ld_occ_ff <= ld_occ_in;
      cnt_ff    <= cnt_in;
      base_ff   <= base_in;
      mask_ff   <= mask_in;
      off_ff    <= off_in;
      ok_a_ff   <= ok_a_in;
      ok_b_ff   <= ok_b_in;
      hit_ff    <= hit_in;
   end

endmodule

FILE: design/occupancy_grid_box_collision_top.sv
// Occupancy grid box collision check: every cycle of use.
//
// Channels: req_* takes items; req_tuser is the kind (0 load, 1 query).
// A load writes one cell of a 4096-cell occupancy bitmap (value above
// zero or -1 marks it occupied) and gives no result. A query returns one
// rsp_* transfer whose bit 0 is 1 when an occupied cell of the configured
// grid lies inside the square box around (pos_x, pos_y).
// csr_* writes the grid size, cell size and origin; write only while idle.
// One item is in work at a time; a query stops at the first hit. The
// column mask sweep takes one column a cycle; each grid row whose
// center lies in the box is then read over both bitmap ports, and
// its result is checked in the state after the read.
// Reset clears the control and configuration registers and the 64
// word-valid flags, so the whole bitmap reads as free at once with no clearing pass.
// If rsp_tready is low the result is held in the output register; the
// next query's result waits until that slot frees, and req_tready stays
// low meanwhile.
`timescale 1ns / 1ps
`include "occupancy_grid_box_collision_top_defines.svh"

module occupancy_grid_box_collision_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request: cell_index[11:0], cell_value[19:12], pos_x[51:20],
   // pos_y[83:52], box_size[103:84]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ogbc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 req_tuser,   // action
   // Response: collision[0], zeros above
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ogbc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // Configuration writes
   input  logic                                 csr_we,
   input  logic [ogbc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ogbc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [ogbc_pkg::GRID_REG_W-1:0]  grid_width_ff, grid_width_in;
   logic [ogbc_pkg::GRID_REG_W-1:0]  grid_height_ff, grid_height_in;
   logic [ogbc_pkg::CELL_SIZE_W-1:0] cell_size_ff, cell_size_in;
   logic signed [ogbc_pkg::COORD_W-1:0] origin_x_ff, origin_x_in;
   logic signed [ogbc_pkg::COORD_W-1:0] origin_y_ff, origin_y_in;

   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic rsp_collision_ff, rsp_collision_in;

   logic                                req_accept;
   logic                                out_free;
   logic        [ogbc_pkg::IDX_W-1:0]   cell_index;
   logic signed [ogbc_pkg::VAL_W-1:0]   cell_value;
   logic signed [ogbc_pkg::COORD_W-1:0] pos_x;
   logic signed [ogbc_pkg::COORD_W-1:0] pos_y;
   logic        [ogbc_pkg::BOX_W-1:0]   box_size;

   ogbc_pkg::span_ctl_type xspan_ctl;
   ogbc_pkg::span_ctl_type yspan_ctl;
   ogbc_pkg::result_type   res;
   logic                   x_hit;
   logic                   y_hit;

   logic                            wr_en;
   logic [ogbc_pkg::MEM_AW-1:0]     wr_addr;
   logic [ogbc_pkg::MAX_DIM-1:0]    wr_data;
   logic [ogbc_pkg::MEM_AW-1:0]     rd_addr_a;
   logic [ogbc_pkg::MEM_AW-1:0]     rd_addr_b;
   logic [ogbc_pkg::MAX_DIM-1:0]    rd_data_a;
   logic [ogbc_pkg::MAX_DIM-1:0]    rd_data_b;

   // Request payload unpacking
   assign req_accept = req_tvalid && req_tready;
   assign cell_index = req_tdata[ogbc_pkg::CELL_INDEX_LSB +: ogbc_pkg::IDX_W];
   assign cell_value = $signed(req_tdata[ogbc_pkg::CELL_VALUE_LSB +: ogbc_pkg::VAL_W]);
   assign pos_x      = $signed(req_tdata[ogbc_pkg::POS_X_LSB +: ogbc_pkg::COORD_W]);
   assign pos_y      = $signed(req_tdata[ogbc_pkg::POS_Y_LSB +: ogbc_pkg::COORD_W]);
   assign box_size   = req_tdata[ogbc_pkg::BOX_SIZE_LSB +: ogbc_pkg::BOX_W];

   // Configuration register writes
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      cell_size_in   = cell_size_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      if (csr_we) begin
         case (csr_addr)
            ogbc_pkg::CSR_GRID_WIDTH:  grid_width_in  = csr_wdata[ogbc_pkg::GRID_REG_W-1:0];
            ogbc_pkg::CSR_GRID_HEIGHT: grid_height_in = csr_wdata[ogbc_pkg::GRID_REG_W-1:0];
            ogbc_pkg::CSR_CELL_SIZE:   cell_size_in   = csr_wdata[ogbc_pkg::CELL_SIZE_W-1:0];
            ogbc_pkg::CSR_ORIGIN_X:    origin_x_in    = $signed(csr_wdata[ogbc_pkg::COORD_W-1:0]);
            ogbc_pkg::CSR_ORIGIN_Y:    origin_y_in    = $signed(csr_wdata[ogbc_pkg::COORD_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= ogbc_pkg::GRID_WIDTH_RST;
         grid_height_ff <= ogbc_pkg::GRID_HEIGHT_RST;
         cell_size_ff   <= ogbc_pkg::CELL_SIZE_RST;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         cell_size_ff   <= cell_size_in;
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
      end
   end

   // Output register: holds a result until its transfer completes
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in    = rsp_tvalid_ff;
      rsp_collision_in = rsp_collision_ff;
      if (res.valid) begin
         rsp_tvalid_in    = 1'b1;
         rsp_collision_in = res.collision;
      end else if (rsp_tready) begin
         rsp_tvalid_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_collision_ff <= rsp_collision_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(ogbc_pkg::RSP_TDATA_W-1){1'b0}}, rsp_collision_ff};

   // Occupancy bitmap, one 64-cell word per entry
   ogbc_ram #(
      .WIDTH (ogbc_pkg::MAX_DIM),
      .DEPTH (ogbc_pkg::MEM_DEPTH)
   ) u_map (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // Column and row sweep units
   ogbc_span u_xspan (
      .clock     (clock),
      .ctl       (xspan_ctl),
      .pos       (pos_x),
      .origin    (origin_x_ff),
      .cell_size (cell_size_ff),
      .box_size  (box_size),
      .hit       (x_hit)
   );

   ogbc_span u_yspan (
      .clock     (clock),
      .ctl       (yspan_ctl),
      .pos       (pos_y),
      .origin    (origin_y_ff),
      .cell_size (cell_size_ff),
      .box_size  (box_size),
      .hit       (y_hit)
   );

   // Sequencer
   ogbc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_action  (req_tuser),
      .cell_index  (cell_index),
      .cell_value  (cell_value),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .out_free    (out_free),
      .req_ready   (req_tready),
      .xspan_ctl   (xspan_ctl),
      .yspan_ctl   (yspan_ctl),
      .x_hit       (x_hit),
      .y_hit       (y_hit),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .rd_data_a   (rd_data_a),
      .rd_data_b   (rd_data_b),
      .result      (res)
   );

   // A finished query only lands when the output slot is free
   `OGBC_ASSERT_IMP(a_result_slot_free, clock, reset, res.valid, !rsp_tvalid_ff || rsp_tready)

   // One item at a time: no transfer right after an accepted one
   `OGBC_ASSERT_NXT(a_busy_after_accept, clock, reset, req_accept, !req_tready)

   // A load never produces a result on the following cycle
   `OGBC_ASSERT_NXT(a_load_no_result, clock, reset,
      req_accept && (req_tuser == ogbc_pkg::ACT_LOAD), !res.valid)

endmodule
